[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the sorted insert table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

// condition never holds
`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`define ASSERT_NEVER(label, clk, rstn, cond)

`endif

`endif

[src/suit_pkg.sv]
// ----------------------------------------------------------------------------
// suit_pkg
// Types and constants shared by the sorted insert table and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package suit_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int UNIT_W      = 3;
    localparam int LEN_W       = 16;
    localparam int POS_W       = 4;

    // one stored key
    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic [LEN_W-1:0]  len;
    } entry_t;

    // data handed from one cell to its right neighbor
    typedef struct packed {
        entry_t entry;
        logic   ge;     // new key sorts before this cell's key, or cell is empty
    } cell_link_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // reported position is the table index reduced to its low bits
    function automatic logic [POS_W-1:0] to_pos(input logic [IDX_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

[src/suit_cell.sv]
// ----------------------------------------------------------------------------
// suit_cell
// One table slot: holds a key, compares it with the lookup key and takes
// either the new key or its left neighbor's key when an insert commits.
// ----------------------------------------------------------------------------
`default_nettype none

module suit_cell (
    input  logic                       aclk,
    input  logic [suit_pkg::IDX_W-1:0] cell_idx,
    input  logic [suit_pkg::CNT_W-1:0] entry_count,
    input  suit_pkg::entry_t           key,
    input  suit_pkg::cell_link_t       left_link,
    input  logic                       load_en,
    output suit_pkg::cell_link_t       right_link,
    output logic                       match,
    output logic                       ins_point
);
    import suit_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   occupied;
    logic   sorts_after;
    logic   ge;

    // compare stage
    always_comb begin
        occupied    = CNT_W'(cell_idx) < entry_count;
        sorts_after = (entry_reg.unit > key.unit) ||
                      ((entry_reg.unit == key.unit) && (entry_reg.len < key.len));
        ge        = !occupied || sorts_after;
        match     = occupied && (entry_reg == key);
        ins_point = ge && !left_link.ge;
    end

    // shift or load
    always_comb begin
        entry_next = entry_reg;
        if (ins_point) begin
            entry_next = key;
        end else if (left_link.ge) begin
            entry_next = left_link.entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            entry_reg <= entry_next;
        end
    end

    assign right_link.entry = entry_reg;
    assign right_link.ge    = ge;

endmodule

`default_nettype wire

[src/sorted_unique_insert_table.sv]
// The key is latched on acceptance, compared by the row in ST_RUN and the result registered.
// A new key is taken only in ST_IDLE; the row of cells compares and shifts in one step.
// Output register holds a result until taken; a stalled result holds the row.
// Reset (aresetn low, synchronous) clears the entry count and handshake state;
// stored keys are not cleared and become valid only as inserts fill the table.
// ----------------------------------------------------------------------------
// sorted_unique_insert_table
// Sorted set of distinct {unit, length} keys kept in a row of compare/shift
// cells; returns position of an existing or newly inserted key, or flags a full table.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sorted_unique_insert_table (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [suit_pkg::UNIT_W-1:0] s_time_unit,
    input  logic [suit_pkg::LEN_W-1:0]  s_step_length,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [suit_pkg::POS_W-1:0]  m_position,
    output logic                        m_already_present,
    output logic                        m_table_full
);
    import suit_pkg::*;

    state_t              state_reg, state_next;
    entry_t              key_reg;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                m_valid_reg, m_valid_next;
    logic [POS_W-1:0]    m_pos_reg;
    logic                m_present_reg;
    logic                m_full_reg;

    cell_link_t          links [TABLE_DEPTH+1];
    logic [TABLE_DEPTH-1:0] match_vec;
    logic [TABLE_DEPTH-1:0] ins_vec;
    logic [TABLE_DEPTH-1:0] sel_vec;
    logic                any_match;
    logic                full;
    logic                commit;
    logic                do_insert;
    logic [IDX_W-1:0]    sel_idx;

    assign links[0] = '{entry: '0, ge: 1'b0};

    // row of cells
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        suit_cell u_cell (
            .aclk        (aclk),
            .cell_idx    (IDX_W'(i)),
            .entry_count (cnt_reg),
            .key         (key_reg),
            .left_link   (links[i]),
            .load_en     (do_insert),
            .right_link  (links[i+1]),
            .match       (match_vec[i]),
            .ins_point   (ins_vec[i])
        );
    end

    // lookup result
    always_comb begin
        any_match = |match_vec;
        full      = cnt_reg >= CNT_W'(TABLE_DEPTH);
        commit    = (state_reg == ST_RUN) && (!m_valid_reg || m_ready);
        do_insert = commit && !any_match && !full;
        if (any_match) begin
            sel_vec = match_vec;
        end else if (full) begin
            sel_vec = '0;
        end else begin
            sel_vec = ins_vec;
        end
        sel_idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            sel_idx = sel_idx | (sel_vec[i] ? IDX_W'(i) : '0);
        end
    end

    // control
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (commit) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (do_insert) begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            key_reg.unit <= s_time_unit;
            key_reg.len  <= s_step_length;
        end
        if (commit) begin
            m_pos_reg     <= to_pos(sel_idx);
            m_present_reg <= any_match;
            m_full_reg    <= full && !any_match;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_position        = m_pos_reg;
    assign m_already_present = m_present_reg;
    assign m_table_full      = m_full_reg;

    // checks
    `ASSERT_NEVER(a_cnt_range, aclk, aresetn, cnt_reg > CNT_W'(TABLE_DEPTH))
    `ASSERT_IMPLIES(a_match_unique, aclk, aresetn, state_reg == ST_RUN, $onehot0(match_vec))
    `ASSERT_IMPLIES(a_ins_unique, aclk, aresetn, state_reg == ST_RUN && !full, $onehot(ins_vec))
    `ASSERT_NEXT(a_cnt_step, aclk, aresetn, do_insert, cnt_reg == $past(cnt_reg) + CNT_W'(1))
    `ASSERT_NEVER(a_flags, aclk, aresetn, m_valid_reg && m_present_reg && m_full_reg)

endmodule

`default_nettype wire
